### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication from a trigger to a consequence on the same edge
`define ASSERT_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ((trig) |-> (cons))) \
    else $error(msg);

`endif

### hw/rtl/tae_pkg.sv
`default_nettype none
package tae_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int ENTRY_FRAC  = 16;
  localparam int NUM_ENTRIES = 6;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int NUM_W  = MAG_W + ENTRY_FRAC;
  localparam int REM_W  = ROOT_W + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_a;
    logic signed [COORD_WIDTH-1:0] y_a;
    logic signed [COORD_WIDTH-1:0] x_b;
    logic signed [COORD_WIDTH-1:0] y_b;
    logic signed [COORD_WIDTH-1:0] x_c;
    logic signed [COORD_WIDTH-1:0] y_c;
    logic signed [COORD_WIDTH-1:0] height_a;
    logic signed [COORD_WIDTH-1:0] height_b;
    logic signed [COORD_WIDTH-1:0] height_c;
  } tri_t;

  typedef struct packed {
    logic signed [ENTRY_WIDTH-1:0] entry_aa;
    logic signed [ENTRY_WIDTH-1:0] entry_bb;
    logic signed [ENTRY_WIDTH-1:0] entry_cc;
    logic signed [ENTRY_WIDTH-1:0] entry_ab;
    logic signed [ENTRY_WIDTH-1:0] entry_ac;
    logic signed [ENTRY_WIDTH-1:0] entry_bc;
    logic                          degenerate;
  } elem_t;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0][MAG_W-1:0] dmag;
    logic [NUM_ENTRIES-1:0]            dneg;
    logic                              deg;
  } side_t;

  typedef struct packed {
    logic neg;
    logic deg;
  } div_side_t;

endpackage
`default_nettype wire

### hw/rtl/tae_sqrt.sv
`default_nettype none
module tae_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ce,
  input  wire logic                        src_valid,
  input  wire logic [tae_pkg::SUM_W-1:0]   radicand,
  input  wire tae_pkg::side_t              src_side,
  output logic                             res_valid,
  output logic [tae_pkg::ROOT_W-1:0]       root,
  output tae_pkg::side_t                   res_side
);
  import tae_pkg::*;

  logic              vld  [ROOT_W];
  logic [SUM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] res  [ROOT_W];
  side_t             side [ROOT_W];

  // one root bit per stage, msb first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic              pv;
    logic [SUM_W-1:0]  prem;
    logic [ROOT_W-1:0] pres;
    side_t             ps;
    logic [SUM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign pv   = src_valid;
      assign prem = radicand;
      assign pres = '0;
      assign ps   = src_side;
    end else begin : g_next
      assign pv   = vld[j-1];
      assign prem = rem[j-1];
      assign pres = res[j-1];
      assign ps   = side[j-1];
    end

    assign trial = (SUM_W'(pres) << (K + 1)) | (SUM_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (ce) begin
        vld[j] <= pv;
      end
      if (ce) begin
        if (trial <= prem) begin
          rem[j] <= prem - trial;
          res[j] <= pres | (ROOT_W'(1) << K);
        end else begin
          rem[j] <= prem;
          res[j] <= pres;
        end
        side[j] <= ps;
      end
    end
  end

  assign res_valid = vld[ROOT_W-1];
  assign root      = res[ROOT_W-1];
  assign res_side  = side[ROOT_W-1];

endmodule
`default_nettype wire

### hw/rtl/tae_div.sv
`default_nettype none
module tae_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ce,
  input  wire logic                        src_valid,
  input  wire logic [tae_pkg::MAG_W-1:0]   dividend,
  input  wire logic [tae_pkg::ROOT_W-1:0]  divisor,
  input  wire tae_pkg::div_side_t          src_side,
  output logic                             res_valid,
  output logic [tae_pkg::NUM_W-1:0]        quotient,
  output logic                             round_up,
  output tae_pkg::div_side_t               res_side
);
  import tae_pkg::*;

  logic              vld  [NUM_W];
  logic [REM_W-1:0]  rem  [NUM_W];
  logic [NUM_W-1:0]  num  [NUM_W];
  logic [ROOT_W-1:0] dvs  [NUM_W];
  div_side_t         side [NUM_W];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [NUM_W-1:0]  pnum;
    logic [ROOT_W-1:0] pdvs;
    div_side_t         ps;
    logic [REM_W-1:0]  shifted;
    logic              ge;

    if (j == 0) begin : g_first
      assign pv   = src_valid;
      assign prem = '0;
      assign pnum = {dividend, {ENTRY_FRAC{1'b0}}};
      assign pdvs = divisor;
      assign ps   = src_side;
    end else begin : g_next
      assign pv   = vld[j-1];
      assign prem = rem[j-1];
      assign pnum = num[j-1];
      assign pdvs = dvs[j-1];
      assign ps   = side[j-1];
    end

    assign shifted = {prem[REM_W-2:0], pnum[NUM_W-1]};
    assign ge      = shifted >= REM_W'(pdvs);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (ce) begin
        vld[j] <= pv;
      end
      if (ce) begin
        rem[j]  <= ge ? shifted - REM_W'(pdvs) : shifted;
        num[j]  <= {pnum[NUM_W-2:0], ge};
        dvs[j]  <= pdvs;
        side[j] <= ps;
      end
    end
  end

  assign res_valid = vld[NUM_W-1];
  assign quotient  = num[NUM_W-1];
  assign round_up  = {rem[NUM_W-1], 1'b0} >= (REM_W + 1)'(dvs[NUM_W-1]);
  assign res_side  = side[NUM_W-1];

endmodule
`default_nettype wire

### hw/rtl/triangle_area_element_matrix.sv
// throughput: one triangle per cycle while triangle_stall is low;
//   seven arithmetic stages, a 35-stage square root, six 50-stage dividers
//   and two rounding stages, all pipelined
// one skid register parts the output from the pipeline under stall
// reset: synchronous, active high; clears all valid bits and the skid flag
`default_nettype none
`include "assert_macros.svh"
module triangle_area_element_matrix (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            triangle_valid,
  output logic                 triangle_stall,
  input  wire tae_pkg::tri_t   triangle,
  output logic                 element_valid,
  input  wire logic            element_stall,
  output tae_pkg::elem_t       element
);
  import tae_pkg::*;

  localparam logic [NUM_W:0] POS_LIM = (NUM_W + 1)'((64'd1 << (ENTRY_WIDTH - 1)) - 64'd1);
  localparam logic [NUM_W:0] NEG_LIM = POS_LIM + (NUM_W + 1)'(1);

  logic ce;
  logic skid_full;
  elem_t skid_data;

  assign ce = !skid_full;

  // s1: differences
  logic v1;
  logic signed [DIFF_W-1:0] s1_ux, s1_uy, s1_uz, s1_vx, s1_vy, s1_vz;
  logic signed [DIFF_W-1:0] s1_nax, s1_nay, s1_nbx, s1_nby;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_ux  <= DIFF_W'(triangle.x_b) - DIFF_W'(triangle.x_a);
      s1_uy  <= DIFF_W'(triangle.y_b) - DIFF_W'(triangle.y_a);
      s1_uz  <= DIFF_W'(triangle.height_b) - DIFF_W'(triangle.height_a);
      s1_vx  <= DIFF_W'(triangle.x_c) - DIFF_W'(triangle.x_a);
      s1_vy  <= DIFF_W'(triangle.y_c) - DIFF_W'(triangle.y_a);
      s1_vz  <= DIFF_W'(triangle.height_c) - DIFF_W'(triangle.height_a);
      s1_nax <= DIFF_W'(triangle.x_c) - DIFF_W'(triangle.x_b);
      s1_nay <= DIFF_W'(triangle.y_c) - DIFF_W'(triangle.y_b);
      s1_nbx <= DIFF_W'(triangle.x_a) - DIFF_W'(triangle.x_c);
      s1_nby <= DIFF_W'(triangle.y_a) - DIFF_W'(triangle.y_c);
    end
  end

  // dot product operands, in entry order aa bb cc ab ac bc
  logic signed [DIFF_W-1:0] dl_x [NUM_ENTRIES];
  logic signed [DIFF_W-1:0] dl_y [NUM_ENTRIES];
  logic signed [DIFF_W-1:0] dr_x [NUM_ENTRIES];
  logic signed [DIFF_W-1:0] dr_y [NUM_ENTRIES];

  always_comb begin
    dl_x[0] = s1_nax; dl_y[0] = s1_nay; dr_x[0] = s1_nax; dr_y[0] = s1_nay;
    dl_x[1] = s1_nbx; dl_y[1] = s1_nby; dr_x[1] = s1_nbx; dr_y[1] = s1_nby;
    dl_x[2] = s1_ux;  dl_y[2] = s1_uy;  dr_x[2] = s1_ux;  dr_y[2] = s1_uy;
    dl_x[3] = s1_nax; dl_y[3] = s1_nay; dr_x[3] = s1_nbx; dr_y[3] = s1_nby;
    dl_x[4] = s1_nax; dl_y[4] = s1_nay; dr_x[4] = s1_ux;  dr_y[4] = s1_uy;
    dl_x[5] = s1_nbx; dl_y[5] = s1_nby; dr_x[5] = s1_ux;  dr_y[5] = s1_uy;
  end

  // s2: products
  logic v2;
  logic signed [PROD_W-1:0] s2_dpx [NUM_ENTRIES];
  logic signed [PROD_W-1:0] s2_dpy [NUM_ENTRIES];
  logic signed [PROD_W-1:0] s2_cpa [3];
  logic signed [PROD_W-1:0] s2_cpb [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        s2_dpx[k] <= dl_x[k] * dr_x[k];
        s2_dpy[k] <= dl_y[k] * dr_y[k];
      end
      s2_cpa[0] <= s1_ux * s1_vy;
      s2_cpb[0] <= s1_uy * s1_vx;
      s2_cpa[1] <= s1_ux * s1_vz;
      s2_cpb[1] <= s1_vx * s1_uz;
      s2_cpa[2] <= s1_uy * s1_vz;
      s2_cpb[2] <= s1_vy * s1_uz;
    end
  end

  // s3: sums and cross terms
  logic v3;
  logic signed [ACC_W-1:0] s3_d  [NUM_ENTRIES];
  logic signed [ACC_W-1:0] s3_cr [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        s3_d[k] <= ACC_W'(s2_dpx[k]) + ACC_W'(s2_dpy[k]);
      end
      for (int k = 0; k < 3; k++) begin
        s3_cr[k] <= ACC_W'(s2_cpa[k]) - ACC_W'(s2_cpb[k]);
      end
    end
  end

  // s4: magnitudes
  logic v4;
  logic [MAG_W-1:0]       s4_cm [3];
  logic [NUM_ENTRIES-1:0][MAG_W-1:0] s4_dm;
  logic [NUM_ENTRIES-1:0] s4_dn;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        s4_dn[k] <= s3_d[k][ACC_W-1];
        s4_dm[k] <= s3_d[k][ACC_W-1] ? MAG_W'(-s3_d[k]) : MAG_W'(s3_d[k]);
      end
      for (int k = 0; k < 3; k++) begin
        s4_cm[k] <= s3_cr[k][ACC_W-1] ? MAG_W'(-s3_cr[k]) : MAG_W'(s3_cr[k]);
      end
    end
  end

  // s5: partial products of the squares
  logic v5;
  logic [2*HALF_W-1:0] s5_hh [3];
  logic [2*HALF_W-1:0] s5_hl [3];
  logic [2*HALF_W-1:0] s5_ll [3];
  side_t s5_side, s6_side, s7_side;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        s5_hh[k] <= s4_cm[k][MAG_W-1:HALF_W] * s4_cm[k][MAG_W-1:HALF_W];
        s5_hl[k] <= s4_cm[k][MAG_W-1:HALF_W] * s4_cm[k][HALF_W-1:0];
        s5_ll[k] <= s4_cm[k][HALF_W-1:0] * s4_cm[k][HALF_W-1:0];
      end
      s5_side.dmag <= s4_dm;
      s5_side.dneg <= s4_dn;
      s5_side.deg  <= (s4_cm[0] == '0) && (s4_cm[1] == '0) && (s4_cm[2] == '0);
    end
  end

  // s6: squares
  logic v6;
  logic [SQ_W-1:0] s6_sq [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= (SQ_W'(s5_hh[k]) << (2 * HALF_W)) + (SQ_W'(s5_hl[k]) << (HALF_W + 1))
                    + SQ_W'(s5_ll[k]);
      end
      s6_side <= s5_side;
    end
  end

  // s7: sum of squares
  logic v7;
  logic [SUM_W-1:0] s7_sum;

  always_ff @(posedge clk) begin
    if (ce) begin
      s7_sum  <= SUM_W'(s6_sq[0]) + SUM_W'(s6_sq[1]) + SUM_W'(s6_sq[2]);
      s7_side <= s6_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (ce) begin
      v1 <= triangle_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  tae_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .src_valid (v7),
    .radicand  (s7_sum),
    .src_side  (s7_side),
    .res_valid (sq_valid),
    .root      (sq_root),
    .res_side  (sq_side)
  );

  logic [NUM_ENTRIES-1:0] dv_valid;
  logic [NUM_W-1:0]       dv_quo [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] dv_rnd;
  div_side_t              dv_side [NUM_ENTRIES];

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_lane
    div_side_t lane_side;
    assign lane_side.neg = sq_side.dneg[k];
    assign lane_side.deg = sq_side.deg;

    tae_div u_div (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .src_valid (sq_valid),
      .dividend  (sq_side.dmag[k]),
      .divisor   (sq_root),
      .src_side  (lane_side),
      .res_valid (dv_valid[k]),
      .quotient  (dv_quo[k]),
      .round_up  (dv_rnd[k]),
      .res_side  (dv_side[k])
    );
  end

  // r1: round half away from zero
  logic                   r1_valid;
  logic [NUM_W:0]         r1_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] r1_neg;
  logic                   r1_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (ce) begin
      r1_valid <= dv_valid[0];
    end
    if (ce) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        r1_q[k]   <= (NUM_W + 1)'(dv_quo[k]) + (NUM_W + 1)'(dv_rnd[k]);
        r1_neg[k] <= dv_side[k].neg;
      end
      r1_deg <= dv_side[0].deg;
    end
  end

  // r2: saturate, sign, zero on degenerate area
  logic signed [ENTRY_WIDTH-1:0] ent [NUM_ENTRIES];

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      logic [NUM_W:0]         lim;
      logic [ENTRY_WIDTH-1:0] val;
      lim = r1_neg[k] ? NEG_LIM : POS_LIM;
      val = (r1_q[k] > lim) ? ENTRY_WIDTH'(lim) : ENTRY_WIDTH'(r1_q[k]);
      if (r1_deg) begin
        ent[k] = '0;
      end else if (r1_neg[k]) begin
        ent[k] = -val;
      end else begin
        ent[k] = val;
      end
    end
  end

  logic  r2_valid;
  elem_t r2_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (ce) begin
      r2_valid <= r1_valid;
    end
    if (ce) begin
      r2_out.entry_aa   <= ent[0];
      r2_out.entry_bb   <= ent[1];
      r2_out.entry_cc   <= ent[2];
      r2_out.entry_ab   <= ent[3];
      r2_out.entry_ac   <= ent[4];
      r2_out.entry_bc   <= ent[5];
      r2_out.degenerate <= r1_deg;
    end
  end

  // skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full) begin
      skid_full <= r2_valid && element_stall;
    end else if (!element_stall) begin
      skid_full <= 1'b0;
    end
    if (!skid_full) begin
      skid_data <= r2_out;
    end
  end

  assign triangle_stall = skid_full;
  assign element_valid  = skid_full || r2_valid;
  assign element        = skid_full ? skid_data : r2_out;

  `ASSERT_CLK(a_skid_fill, (skid_full && !$past(skid_full)) |-> $past(r2_valid && element_stall),
    "skid filled without a stalled beat")
  `ASSERT_CLK(a_frozen, skid_full |=> $stable(r2_valid) && $stable(r2_out),
    "pipeline moved while skid full")
  `ASSERT_IMPLY(a_deg_zero, element_valid && element.degenerate,
    element.entry_aa == 0 && element.entry_bb == 0 && element.entry_cc == 0 &&
    element.entry_ab == 0 && element.entry_ac == 0 && element.entry_bc == 0,
    "degenerate beat with nonzero entries")

endmodule
`default_nettype wire

### tb/sv/tae_checker.sv
`timescale 1ns / 1ps
module tae_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           triangle_valid,
  input  logic           triangle_stall,
  input  tae_pkg::tri_t  triangle,
  input  logic           element_valid,
  input  logic           element_stall,
  input  tae_pkg::elem_t element,
  output int             errors,
  output int             pending
);
  import tae_pkg::*;

  elem_t expected_elems[$];

  function automatic logic [ENTRY_WIDTH-1:0] scaled_entry(longint d, logic [127:0] root);
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] lim;
    logic         neg;
    neg = d < 0;
    n = neg ? 128'(-d) : 128'(d);
    n = n << ENTRY_FRAC;
    q = n / root;
    r = n % root;
    if (r >= root - r) q = q + 1;
    lim = neg ? (128'd1 << (ENTRY_WIDTH - 1)) : ((128'd1 << (ENTRY_WIDTH - 1)) - 1);
    if (q > lim) q = lim;
    return neg ? -q[ENTRY_WIDTH-1:0] : q[ENTRY_WIDTH-1:0];
  endfunction

  function automatic elem_t element_matrix(tri_t t);
    longint xa, ya, xb, yb, xc, yc, ha, hb, hc;
    longint nax, nay, nbx, nby, ncx, ncy, uz, vz;
    logic signed [127:0] p, q, r;
    logic [127:0] area_sq;
    logic [127:0] root;
    logic [63:0]  cand;
    elem_t e;
    xa = t.x_a; ya = t.y_a; xb = t.x_b; yb = t.y_b; xc = t.x_c; yc = t.y_c;
    ha = t.height_a; hb = t.height_b; hc = t.height_c;
    nax = xc - xb; nay = yc - yb;
    nbx = xa - xc; nby = ya - yc;
    ncx = xb - xa; ncy = yb - ya;
    uz = hb - ha; vz = hc - ha;
    p = (xb - xa) * (yc - ya) - (yb - ya) * (xc - xa);
    q = (xb - xa) * vz - (xc - xa) * uz;
    r = (yb - ya) * vz - (yc - ya) * uz;
    area_sq = p * p + q * q + r * r;
    e = '0;
    if (area_sq == 0) begin
      e.degenerate = 1'b1;
      return e;
    end
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root[63:0] | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= area_sq) root = {64'd0, cand};
    end
    e.entry_aa = scaled_entry(nax * nax + nay * nay, root);
    e.entry_bb = scaled_entry(nbx * nbx + nby * nby, root);
    e.entry_cc = scaled_entry(ncx * ncx + ncy * ncy, root);
    e.entry_ab = scaled_entry(nax * nbx + nay * nby, root);
    e.entry_ac = scaled_entry(nax * ncx + nay * ncy, root);
    e.entry_bc = scaled_entry(nbx * ncx + nby * ncy, root);
    return e;
  endfunction

  assign pending = expected_elems.size();

  always @(posedge clk) begin
    elem_t want;
    if (!rst) begin
      if (triangle_valid && !triangle_stall) expected_elems.push_back(element_matrix(triangle));
      if (element_valid && !element_stall) begin
        if (expected_elems.size() == 0) begin
          errors++;
          $display("%0t: unexpected element beat %h", $time, element);
        end else begin
          want = expected_elems.pop_front();
          if (element.entry_aa !== want.entry_aa) begin
            errors++;
            $display("%0t: entry_aa exp %h got %h", $time, want.entry_aa, element.entry_aa);
          end
          if (element.entry_bb !== want.entry_bb) begin
            errors++;
            $display("%0t: entry_bb exp %h got %h", $time, want.entry_bb, element.entry_bb);
          end
          if (element.entry_cc !== want.entry_cc) begin
            errors++;
            $display("%0t: entry_cc exp %h got %h", $time, want.entry_cc, element.entry_cc);
          end
          if (element.entry_ab !== want.entry_ab) begin
            errors++;
            $display("%0t: entry_ab exp %h got %h", $time, want.entry_ab, element.entry_ab);
          end
          if (element.entry_ac !== want.entry_ac) begin
            errors++;
            $display("%0t: entry_ac exp %h got %h", $time, want.entry_ac, element.entry_ac);
          end
          if (element.entry_bc !== want.entry_bc) begin
            errors++;
            $display("%0t: entry_bc exp %h got %h", $time, want.entry_bc, element.entry_bc);
          end
          if (element.degenerate !== want.degenerate) begin
            errors++;
            $display("%0t: degenerate exp %b got %b", $time, want.degenerate,
                     element.degenerate);
          end
        end
      end
    end
  end
endmodule

### tb/sv/tb_triangle_area_element_matrix.sv
`timescale 1ns / 1ps
module tb_triangle_area_element_matrix;
  import tae_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_TRIANGLES = 830;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  triangle_valid = 1'b0;
  logic  triangle_stall;
  tri_t  triangle = '0;
  logic  element_valid;
  logic  element_stall = 1'b1;
  elem_t element;
  int    errors;
  int    pending;
  int    cycles = 0;
  int    beats_out = 0;
  logic  no_idle = 1'b0;
  logic  tri_taken = 1'b0;
  logic  elem_taken = 1'b0;

  always #6 clk = ~clk;

  triangle_area_element_matrix u_top (
    .clk(clk), .rst(rst),
    .triangle_valid(triangle_valid), .triangle_stall(triangle_stall), .triangle(triangle),
    .element_valid(element_valid), .element_stall(element_stall), .element(element)
  );

  tae_checker u_checker (
    .clk(clk), .rst(rst),
    .triangle_valid(triangle_valid), .triangle_stall(triangle_stall), .triangle(triangle),
    .element_valid(element_valid), .element_stall(element_stall), .element(element),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    tri_taken <= !rst && triangle_valid && !triangle_stall;
    elem_taken <= !rst && element_valid && !element_stall;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_triangle_area_element_matrix NOT OK");
      $finish;
    end
  end

  task automatic send_triangle(tri_t t);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      triangle_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    triangle <= t;
    triangle_valid <= 1'b1;
    do begin
      @(posedge clk);
      @(negedge clk);
    end while (!tri_taken);
  endtask

  function automatic tri_t make_tri(int xa, int ya, int xb, int yb, int xc, int yc,
                                    int ha, int hb, int hc);
    tri_t t;
    t.x_a = 16'(xa); t.y_a = 16'(ya); t.x_b = 16'(xb); t.y_b = 16'(yb);
    t.x_c = 16'(xc); t.y_c = 16'(yc);
    t.height_a = 16'(ha); t.height_b = 16'(hb); t.height_c = 16'(hc);
    return t;
  endfunction

  function automatic logic [15:0] near(logic [15:0] base, int span);
    return base + 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // receiver: random stall per beat, one long hold to back up the pipeline
  initial begin
    int gap;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (!held && beats_out == 120) begin
        held = 1;
        gap = 600;
      end
      if (gap > 0) begin
        element_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      element_stall <= 1'b0;
      do begin
        @(posedge clk);
        @(negedge clk);
      end while (!elem_taken);
      beats_out++;
    end
  end

  initial begin
    tri_t t;
    int kind;
    int settle;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // zero area, extremes, saturation, collinear, vertical, tiny
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_triangle(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                           -32768, 32767, 32767));
    send_triangle(make_tri(-32768, 0, 32767, 0, 0, 1, 0, 0, 0));
    send_triangle(make_tri(-32768, 0, 32767, 1, 32767, 0, 0, 0, 0));
    send_triangle(make_tri(0, -32768, 1, 32767, 0, 32767, 0, 0, 0));
    send_triangle(make_tri(0, 0, 256, 256, 512, 512, 0, 0, 0));
    send_triangle(make_tri(0, 0, 256, 256, 512, 512, 0, 256, 0));
    send_triangle(make_tri(0, 0, 0, 256, 0, 512, 100, -300, 77));
    send_triangle(make_tri(0, 0, 256, 0, 0, 256, 0, 0, 0));
    send_triangle(make_tri(0, 0, 256, 0, 0, 256, 32767, -32768, 32767));
    send_triangle(make_tri(0, 0, 1, 0, 0, 1, 0, 0, 0));
    send_triangle(make_tri(5, 5, 5, 5, 9, -3, 0, 0, 0));
    send_triangle(make_tri(-1, -1, -1, -1, -1, -1, 0, 0, 1));
    send_triangle(make_tri(32767, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
    send_triangle(make_tri(0, 0, 32767, 32767, -32768, -32768, 1, 0, -1));
    for (int i = 0; i < RANDOM_TRIANGLES; i++) begin
      no_idle <= (i >= 400 && i < 480);
      kind = $urandom_range(0, 9);
      t = tri_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
      if (kind < 5) begin
        // a compact mesh-like triangle around a random point
        t.x_b = near(t.x_a, 1024); t.y_b = near(t.y_a, 1024);
        t.x_c = near(t.x_a, 1024); t.y_c = near(t.y_a, 1024);
        t.height_b = near(t.height_a, 512); t.height_c = near(t.height_a, 512);
      end else if (kind == 5) begin
        t.x_c = t.x_b; t.y_c = t.y_b; t.height_c = t.height_b;
      end else if (kind == 6) begin
        t.x_b = near(t.x_a, 2); t.y_b = near(t.y_a, 2);
        t.x_c = near(t.x_a, 2); t.y_c = near(t.y_a, 2);
        t.height_b = near(t.height_a, 2); t.height_c = near(t.height_a, 2);
      end else if (kind == 7) begin
        t.height_b = t.height_a; t.height_c = t.height_a;
      end
      send_triangle(t);
    end
    triangle_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    settle = 0;
    while (settle < 200) begin
      @(negedge clk);
      settle++;
    end
    if (errors == 0) begin
      $display("tb_triangle_area_element_matrix OK");
    end else begin
      $display("tb_triangle_area_element_matrix NOT OK");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tae_pkg.sv
hw/rtl/tae_sqrt.sv
hw/rtl/tae_div.sv
hw/rtl/triangle_area_element_matrix.sv
tb/sv/tae_checker.sv
tb/sv/tb_triangle_area_element_matrix.sv
